// File: rtl/bmr_pkg.sv
// shared types and constants for the bank mapper with real-time clock
`default_nettype none
package bmr_pkg;

  // field widths of the word channels
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned VALUE_W  = 8;
  localparam int unsigned TARGET_W = 2;
  localparam int unsigned MAP_W    = 21;
  localparam int unsigned DATA_W   = 8;

  // configuration port
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [TARGET_W-1:0] {
    TGT_NONE = 2'd0,
    TGT_ROM  = 2'd1,
    TGT_RAM  = 2'd2,
    TGT_RTC  = 2'd3
  } target_t;

  // configuration register indexes (paddr[3:2])
  typedef enum logic [1:0] {
    CFG_TIMER_PRESENT = 2'd0,
    CFG_ROM_BANK_TOP  = 2'd1,
    CFG_RAM_BANK_TOP  = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_reg_t;

  // bus address regions, taken from address[15:13]
  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_BANK   = 3'd1;
  localparam logic [2:0] REG_SELECT = 3'd2;
  localparam logic [2:0] REG_LATCH  = 3'd3;
  localparam logic [2:0] REG_EXTRAM = 3'd5;

  // rtc register select codes
  localparam logic [3:0] RTC_SEC    = 4'h8;
  localparam logic [3:0] RTC_MIN    = 4'h9;
  localparam logic [3:0] RTC_HOUR   = 4'hA;
  localparam logic [3:0] RTC_DAY_LO = 4'hB;
  localparam logic [3:0] RTC_DAY_HI = 4'hC;

  localparam logic [7:0] RAM_ENABLE_KEY = 8'h0A;
  localparam logic [7:0] INVALID_BYTE   = 8'hFF;
  localparam logic [5:0] SEC_PER_MIN    = 6'd60;
  localparam logic [5:0] MIN_PER_HOUR   = 6'd60;
  localparam logic [4:0] HOUR_PER_DAY   = 5'd24;

  // packing of the latched time word
  localparam int unsigned LT_W = 26;
  typedef struct packed {
    logic [8:0] days;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } rtc_time_t;

endpackage
`default_nettype wire

// File: rtl/bmr_in_if.sv
// input word channel: bus access or one-second tick
`default_nettype none
interface bmr_in_if import bmr_pkg::*;;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [ADDR_W-1:0]  address;
  logic [VALUE_W-1:0] value;

  modport source (output valid, kind, address, value, input ready);
  modport sink   (input valid, kind, address, value, output ready);
endinterface
`default_nettype wire

// File: rtl/bmr_out_if.sv
// result word channel: target, banked address, ram strobe and read byte
`default_nettype none
interface bmr_out_if import bmr_pkg::*;;
  logic                valid;
  logic                ready;
  logic [TARGET_W-1:0] target;
  logic [MAP_W-1:0]    mapped_address;
  logic                ram_write;
  logic [DATA_W-1:0]   read_data;

  modport source (output valid, target, mapped_address, ram_write, read_data, input ready);
  modport sink   (input valid, target, mapped_address, ram_write, read_data, output ready);
endinterface
`default_nettype wire

// File: rtl/bank_mapper_with_rtc.sv
// top level: mbc3-style bank controller with real-time clock
`default_nettype none
// bank_mapper_with_rtc decodes cartridge bus words (read, write or one-second
// tick) against its bank and clock state and returns one result word per
// input word. for every word, the decode, the state
// update and the result are computed at the accepting edge and the result is
// held in an output register, so one word per cycle is sustained and the
// input stays ready while a result waits, as long as the output side takes
// words; the only stall is a full output register whose word is not taken.
// the result word gives the target (none, rom, external ram, rtc register),
// the banked address for rom and ram (bank * 16k / 8k plus offset), a ram
// write strobe gated by the enable, and the latched rtc byte on rtc reads or
// 0xff on invalid reads. the three setup registers (timer present, top rom
// bank, top ram bank) sit on an apb port at byte addresses 0, 4 and 8 and
// are to be written only while the block is idle. ROM_BANK_BITS masks the
// rom bank driven into the address; DAY_LIMIT sets where the day counter
// wraps and raises the overflow flag.
module bank_mapper_with_rtc import bmr_pkg::*; #(
  parameter int unsigned ROM_BANK_BITS = 7,
  parameter int unsigned DAY_LIMIT     = 511
) (
  input  wire logic               clk,
  input  wire logic               rst,
  bmr_in_if.sink                  in_ch,
  bmr_out_if.source               out_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam logic [6:0]  BANK_MASK = 7'((1 << ROM_BANK_BITS) - 1);
  localparam logic [9:0]  DAY_TOP   = 10'(DAY_LIMIT);
  localparam logic [10:0] DAY_MOD   = 11'(DAY_LIMIT + 1);
  localparam logic [10:0] DAY_MOD2  = 11'(2 * (DAY_LIMIT + 1));

  // setup registers
  logic       timer_present;
  logic [6:0] rom_bank_top;
  logic [1:0] ram_bank_top;

  // mapper and clock state
  logic       [6:0] rom_bank, rom_bank_next;
  logic       [3:0] ram_rtc_select, ram_rtc_select_next;
  logic             ram_enabled, ram_enabled_next;
  logic       [7:0] last_latch_byte, last_latch_byte_next;
  rtc_time_t        live, live_next;
  rtc_time_t        latched_time, latched_time_next;
  logic             clock_halted, clock_halted_next;
  logic             day_overflow, day_overflow_next;

  // result computed for the word at the input
  target_t           res_target;
  logic [MAP_W-1:0]  res_mapped;
  logic              res_wr;
  logic [DATA_W-1:0] res_rd;

  // output register
  logic              out_valid;
  target_t           out_target;
  logic [MAP_W-1:0]  out_mapped;
  logic              out_wr;
  logic [DATA_W-1:0] out_rd;

  logic       in_accept;
  logic       cfg_write;
  cfg_reg_t   cfg_idx;

  // ------------------------------------------------------------------
  // apb setup port, always ready, index from paddr[3:2]
  // ------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_idx   = cfg_reg_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_present <= 1'b1;
      rom_bank_top  <= 7'd127;
      ram_bank_top  <= 2'd3;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        CFG_TIMER_PRESENT: timer_present <= pwdata[0];
        CFG_ROM_BANK_TOP:  rom_bank_top  <= pwdata[6:0];
        CFG_RAM_BANK_TOP:  ram_bank_top  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_TIMER_PRESENT: prdata = PDATA_W'(timer_present);
      CFG_ROM_BANK_TOP:  prdata = PDATA_W'(rom_bank_top);
      CFG_RAM_BANK_TOP:  prdata = PDATA_W'(ram_bank_top);
      default:           prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // word handshake: the output register frees up as its word is taken
  // ------------------------------------------------------------------
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  // ------------------------------------------------------------------
  // decode, state update and result in one pass
  // ------------------------------------------------------------------
  always_comb begin
    logic [2:0]  region;
    logic        in_ram;
    logic        ram_sel;
    logic        rtc_sel;
    logic [7:0]  val;
    logic [6:0]  sec_inc;
    logic [6:0]  min_inc;
    logic [5:0]  hour_inc;
    logic [10:0] day_wide;
    logic        halt;

    region  = in_ch.address[15:13];
    in_ram  = (region == REG_EXTRAM);
    ram_sel = (ram_rtc_select <= {2'b00, ram_bank_top});
    rtc_sel = (ram_rtc_select >= RTC_SEC) && (ram_rtc_select <= RTC_DAY_HI);
    val     = in_ch.value;
    sec_inc  = '0;
    min_inc  = '0;
    hour_inc = '0;
    day_wide = '0;
    halt     = val[6];

    rom_bank_next        = rom_bank;
    ram_rtc_select_next  = ram_rtc_select;
    ram_enabled_next     = ram_enabled;
    last_latch_byte_next = last_latch_byte;
    live_next            = live;
    latched_time_next    = latched_time;
    clock_halted_next    = clock_halted;
    day_overflow_next    = day_overflow;

    res_target = TGT_NONE;
    res_mapped = '0;
    res_wr     = 1'b0;
    res_rd     = '0;

    unique case (kind_t'(in_ch.kind))
      KIND_READ: begin
        if (!in_ch.address[15]) begin
          // bank 0 window reads its own address, the upper window the bank
          res_target = TGT_ROM;
          if (!in_ch.address[14]) begin
            res_mapped = MAP_W'(in_ch.address[13:0]);
          end else begin
            res_mapped = {rom_bank & BANK_MASK, in_ch.address[13:0]};
          end
        end else if (in_ram && ram_sel) begin
          res_target = TGT_RAM;
          res_mapped = MAP_W'({ram_rtc_select[1:0], in_ch.address[12:0]});
        end else if (in_ram && rtc_sel && timer_present) begin
          res_target = TGT_RTC;
          unique case (ram_rtc_select)
            RTC_SEC:    res_rd = {2'b00, latched_time.seconds};
            RTC_MIN:    res_rd = {2'b00, latched_time.minutes};
            RTC_HOUR:   res_rd = {3'b000, latched_time.hours};
            RTC_DAY_LO: res_rd = latched_time.days[7:0];
            default:    res_rd = {day_overflow, clock_halted, 5'b00000,
                                  latched_time.days[8]};
          endcase
        end else begin
          res_rd = INVALID_BYTE;
        end
      end

      KIND_WRITE: begin
        unique case (region)
          REG_ENABLE: ram_enabled_next = (val == RAM_ENABLE_KEY);
          REG_BANK: begin
            if (val <= {1'b0, rom_bank_top}) begin
              rom_bank_next = (val == 8'd0) ? 7'd1 : val[6:0];
            end
          end
          REG_SELECT: begin
            if ((val <= {6'd0, ram_bank_top}) ||
                (timer_present && val >= {4'd0, RTC_SEC} && val <= {4'd0, RTC_DAY_HI})) begin
              ram_rtc_select_next = val[3:0];
            end
          end
          REG_LATCH: begin
            // a 0 then 1 write sequence copies the live clock
            if (timer_present) begin
              if (last_latch_byte == 8'd0 && val == 8'd1) begin
                latched_time_next = live;
              end
              last_latch_byte_next = val;
            end
          end
          REG_EXTRAM: begin
            if (ram_enabled) begin
              if (ram_sel) begin
                res_target = TGT_RAM;
                res_wr     = 1'b1;
                res_mapped = MAP_W'({ram_rtc_select[1:0], in_ch.address[12:0]});
              end else if (rtc_sel && timer_present) begin
                res_target = TGT_RTC;
                // time and day writes go to both clocks, only while halted
                unique case (ram_rtc_select)
                  RTC_SEC: begin
                    if (clock_halted && val < {2'b00, SEC_PER_MIN}) begin
                      live_next.seconds         = val[5:0];
                      latched_time_next.seconds = val[5:0];
                    end
                  end
                  RTC_MIN: begin
                    if (clock_halted && val < {2'b00, MIN_PER_HOUR}) begin
                      live_next.minutes         = val[5:0];
                      latched_time_next.minutes = val[5:0];
                    end
                  end
                  RTC_HOUR: begin
                    if (clock_halted && val < {3'b000, HOUR_PER_DAY}) begin
                      live_next.hours         = val[4:0];
                      latched_time_next.hours = val[4:0];
                    end
                  end
                  RTC_DAY_LO: begin
                    if (clock_halted) begin
                      live_next.days[7:0]         = val;
                      latched_time_next.days[7:0] = val;
                    end
                  end
                  default: begin
                    // control byte: halt flag, overflow clear, day bit 8
                    if (clock_halted && halt) begin
                      if (!val[7]) begin
                        day_overflow_next = 1'b0;
                      end
                      live_next.days[8]         = val[0];
                      latched_time_next.days[8] = val[0];
                    end
                    clock_halted_next = halt;
                  end
                endcase
              end
            end
          end
          default: ;
        endcase
      end

      KIND_TICK: begin
        if (timer_present && !clock_halted) begin
          sec_inc  = {1'b0, live.seconds} + 7'd1;
          min_inc  = {1'b0, live.minutes};
          hour_inc = {1'b0, live.hours};
          day_wide = {2'b00, live.days};
          if (sec_inc >= {1'b0, SEC_PER_MIN}) begin
            sec_inc = '0;
            min_inc = min_inc + 7'd1;
            if (min_inc >= {1'b0, MIN_PER_HOUR}) begin
              min_inc  = '0;
              hour_inc = hour_inc + 6'd1;
              if (hour_inc >= {1'b0, HOUR_PER_DAY}) begin
                hour_inc = '0;
                day_wide = day_wide + 11'd1;
              end
            end
          end
          // wrap past the day limit; at most two moduli to take off
          if (day_wide > {1'b0, DAY_TOP}) begin
            day_overflow_next = 1'b1;
            if (day_wide >= DAY_MOD2) begin
              day_wide = day_wide - DAY_MOD2;
            end else begin
              day_wide = day_wide - DAY_MOD;
            end
          end
          live_next.seconds = sec_inc[5:0];
          live_next.minutes = min_inc[5:0];
          live_next.hours   = hour_inc[4:0];
          live_next.days    = day_wide[8:0];
        end
      end

      default: ;
    endcase
  end

  // ------------------------------------------------------------------
  // state and output registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank        <= 7'd1;
      ram_rtc_select  <= '0;
      ram_enabled     <= 1'b0;
      last_latch_byte <= '0;
      live            <= '0;
      latched_time    <= '0;
      clock_halted    <= 1'b0;
      day_overflow    <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (in_accept) begin
        rom_bank        <= rom_bank_next;
        ram_rtc_select  <= ram_rtc_select_next;
        ram_enabled     <= ram_enabled_next;
        last_latch_byte <= last_latch_byte_next;
        live            <= live_next;
        latched_time    <= latched_time_next;
        clock_halted    <= clock_halted_next;
        day_overflow    <= day_overflow_next;
        out_valid       <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_target <= res_target;
      out_mapped <= res_mapped;
      out_wr     <= res_wr;
      out_rd     <= res_rd;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.target         = out_target;
  assign out_ch.mapped_address = out_mapped;
  assign out_ch.ram_write      = out_wr;
  assign out_ch.read_data      = out_rd;

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  // a ram write strobe only ever goes out with the external ram target
  a_wr_is_ram: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_wr |-> out_target == TGT_RAM)
    else $error("ram write strobe without ram target");

  // the rom bank register used for the upper rom window never holds zero
  a_bank_nonzero: assert property (@(posedge clk) disable iff (rst)
    rom_bank != 7'd0)
    else $error("rom bank register holds zero");

  // the live clock stays in its legal ranges
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    live.seconds < SEC_PER_MIN && live.minutes < MIN_PER_HOUR &&
    live.hours < HOUR_PER_DAY)
    else $error("live clock out of range");

  // overflow is raised only by an accepted tick
  a_ovf_by_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(day_overflow) |-> $past(in_accept && in_ch.kind == KIND_TICK))
    else $error("day overflow set without a tick");

  // a stalled result word holds while a new word is refused
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(out_mapped) && $stable(out_rd))
    else $error("stalled result word changed");

endmodule
`default_nettype wire
